>>> rtl/core/frt_pkg.sv
// Shared constants, types and status codes of the free range tracker.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none
package frt_pkg;
    localparam int MAX_RANGES = 256;
    localparam int CELL_BITS = 32;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int STEP_W = $clog2(2 * MAX_RANGES + 1);
    localparam logic [CELL_BITS-1:0] TOTAL_RESET = CELL_BITS'(1024);

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_ORDER = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    typedef struct packed {
        logic                 v;
        logic [CELL_BITS-1:0] s;
        logic [CELL_BITS-1:0] e;
    } t_slot;

    typedef struct packed {
        logic [CELL_BITS-1:0] claim;
        logic                 removed;
        logic                 split;
        logic                 reject;
    } t_head_ctl;
endpackage
`default_nettype wire

>>> rtl/core/frt_channels.sv
// Handshake channels of the free range tracker: request, result and configuration.
// Depends on frt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface frt_req_if;
    logic                         valid;
    logic                         ready;
    logic [frt_pkg::CELL_BITS-1:0] range_low;
    logic [frt_pkg::CELL_BITS-1:0] range_high;
    modport source (output valid, output range_low, output range_high, input ready);
    modport sink (input valid, input range_low, input range_high, output ready);
endinterface

interface frt_res_if;
    logic                         valid;
    logic                         ready;
    logic [frt_pkg::CELL_BITS-1:0] free_count;
    logic [1:0]                   status;
    modport source (output valid, output free_count, output status, input ready);
    modport sink (input valid, input free_count, input status, output ready);
endinterface

interface frt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [frt_pkg::CELL_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/frt_cell.sv
// One cell of the interval ring: holds a single free interval and hands it on.
// Depends on frt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire logic          i_load,
    input  wire frt_pkg::t_slot i_init,
    input  wire frt_pkg::t_slot i_next,
    output frt_pkg::t_slot     o_slot
);
    import frt_pkg::*;

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_load) begin
            r_slot <= i_init;
        end else if (i_shift) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;
endmodule
`default_nettype wire

>>> rtl/core/frt_head.sv
// Trims the interval leaving the head of the ring against the claimed range.
// Also fills an empty head cell from the holder. Depends on frt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frt_head (
    input  wire frt_pkg::t_slot              i_slot,
    input  wire frt_pkg::t_slot              i_pend,
    input  wire logic [frt_pkg::CELL_BITS-1:0] i_lo,
    input  wire logic [frt_pkg::CELL_BITS-1:0] i_hi,
    input  wire logic                        i_full,
    output frt_pkg::t_slot                   o_slot,
    output frt_pkg::t_slot                   o_pend,
    output frt_pkg::t_head_ctl               o_ctl
);
    import frt_pkg::*;

    logic                 w_ov;
    logic                 w_left;
    logic                 w_right;
    logic [CELL_BITS-1:0] w_cs;
    logic [CELL_BITS-1:0] w_ce;

    always_comb begin
        w_ov = i_slot.v && (i_slot.s <= i_hi) && (i_slot.e >= i_lo);
        w_left = i_slot.s < i_lo;
        w_right = i_slot.e > i_hi;
        w_cs = w_left ? i_lo : i_slot.s;
        w_ce = w_right ? i_hi : i_slot.e;
        o_slot = i_slot;
        o_pend = i_pend;
        o_ctl = '0;
        if (w_ov) begin
            if (w_left && w_right && i_full) begin
                o_ctl.reject = 1'b1;
            end else begin
                o_ctl.claim = w_ce - w_cs + CELL_BITS'(1);
                if (w_left) begin
                    o_slot.e = i_lo - CELL_BITS'(1);
                    if (w_right) begin
                        o_ctl.split = 1'b1;
                        o_pend = '{v: 1'b1, s: i_hi + CELL_BITS'(1), e: i_slot.e};
                    end
                end else if (w_right) begin
                    o_slot.s = i_hi + CELL_BITS'(1);
                end else begin
                    o_slot.v = 1'b0;
                    o_ctl.removed = 1'b1;
                end
            end
        end else if (!i_slot.v && i_pend.v) begin
            o_slot = i_pend;
            o_pend.v = 1'b0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/free_range_tracker.sv
// Top level of the free range tracker: a ring of interval cells and a head trimmer.
// Depends on frt_pkg, frt_channels, frt_cell and frt_head.
//
// Use: a request word on i_req carries range_low and range_high. The block
// answers each request with exactly one word on o_res: the free count after
// the claim and a status (done, low above high, table full). Free intervals
// live unordered in a ring of MAX_RANGES cells; for each request the ring
// rotates once past the head unit, which trims, removes or splits intervals
// and sums the claimed cells. A split's right piece waits in a holding
// register until an empty cell passes, which may take up to one more turn.
// A request with low above high goes straight to its answer without a turn
// of the ring. One request is in work at a time; i_req.ready is high while
// the block is idle and no configuration word is offered.
// A write on i_cfg reloads the ring with the single interval [1, data] (empty
// for zero). Reset does the same with 1024 cells.
// The result is held in an output register while the receiver stalls; the
// next request is still accepted and waits for that register before answering.
`timescale 1ns / 1ps
`default_nettype none
module free_range_tracker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    frt_req_if.sink   i_req,
    frt_res_if.source o_res,
    frt_cfg_if.sink   i_cfg
);
    import frt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_RESP} t_state;

    t_state               r_state;
    logic [CELL_BITS-1:0] r_lo;
    logic [CELL_BITS-1:0] r_hi;
    t_slot                r_pend;
    logic [STEP_W-1:0]    r_step;
    logic [CNT_W-1:0]     r_count;
    logic [CELL_BITS-1:0] r_free;
    logic                 r_err;
    t_status              r_res_status;
    logic [CELL_BITS-1:0] r_res_free;
    logic                 r_ov;
    logic [CELL_BITS-1:0] r_out_free;
    t_status              r_out_status;

    t_slot     w_slot [MAX_RANGES];
    t_slot     w_head_out;
    t_slot     w_pend;
    t_head_ctl w_ctl;
    t_slot     w_load;
    logic      w_cfg;
    logic      w_acc;
    logic      w_finish;
    logic      w_shift;
    logic      w_out_free;

    assign w_cfg = i_cfg.valid && i_cfg.ready;
    assign w_acc = i_req.valid && i_req.ready;
    assign w_finish = (r_step >= STEP_W'(MAX_RANGES)) && !r_pend.v;
    assign w_shift = (r_state == S_RUN) && !w_finish;
    assign w_out_free = !r_ov || o_res.ready;
    assign w_load = '{v: (i_cfg.data != '0), s: CELL_BITS'(1), e: i_cfg.data};

    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.free_count = r_out_free;
    assign o_res.status = r_out_status;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        frt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_shift),
            .i_load (w_cfg),
            .i_init ((g == 0) ? (i_rst_n ? w_load
                                         : t_slot'{v: 1'b1, s: CELL_BITS'(1), e: TOTAL_RESET})
                              : t_slot'('0)),
            .i_next ((g == MAX_RANGES - 1) ? w_head_out : w_slot[(g + 1) % MAX_RANGES]),
            .o_slot (w_slot[g])
        );
    end

    frt_head u_head (
        .i_slot(w_slot[0]),
        .i_pend(r_pend),
        .i_lo  (r_lo),
        .i_hi  (r_hi),
        .i_full(r_count == CNT_W'(MAX_RANGES)),
        .o_slot(w_head_out),
        .o_pend(w_pend),
        .o_ctl (w_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend <= '0;
            r_step <= '0;
            r_count <= CNT_W'(1);
            r_free <= TOTAL_RESET;
            r_err <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_state == S_RESP && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg) begin
                        r_count <= CNT_W'(i_cfg.data != '0);
                        r_free <= i_cfg.data;
                    end else if (w_acc) begin
                        r_lo <= i_req.range_low;
                        r_hi <= i_req.range_high;
                        r_step <= '0;
                        r_err <= 1'b0;
                        r_pend <= '0;
                        if (i_req.range_low > i_req.range_high) begin
                            r_res_status <= ST_ORDER;
                            r_res_free <= r_free;
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_finish) begin
                        r_res_status <= r_err ? ST_FULL : ST_DONE;
                        r_res_free <= r_free;
                        r_state <= S_RESP;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                        r_pend <= w_pend;
                        r_free <= r_free - w_ctl.claim;
                        if (w_ctl.reject) begin
                            r_err <= 1'b1;
                        end
                        if (w_ctl.removed) begin
                            r_count <= r_count - CNT_W'(1);
                        end else if (w_ctl.split) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_free <= r_res_free;
                        r_out_status <= r_res_status;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("interval count above table size");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend.v)
        else $error("split piece left unplaced");

    a_reject_keeps_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && w_ctl.reject) |-> w_ctl.claim == '0 && !w_ctl.split)
        else $error("rejected split changed the table");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state != S_IDLE)
        else $error("request accepted without work");
endmodule
`default_nettype wire

>>> test/free_range_tracker_test.sv
// Self-checking testbench of the free range tracker: drives claim requests and
// total_cells writes, predicts each free count and status, and checks every result.
// Depends on frt_pkg, frt_channels and the free_range_tracker RTL.
`timescale 1ns / 1ps
`default_nettype none
module free_range_tracker_test;
    import frt_pkg::*;

    typedef logic [CELL_BITS-1:0] t_cell;
    typedef struct packed {
        t_cell   free_count;
        t_status status;
    } t_claim_result;

    logic i_clk;
    logic i_rst_n;
    frt_req_if i_req ();
    frt_res_if o_res ();
    frt_cfg_if i_cfg ();

    free_range_tracker DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req.sink),
        .o_res  (o_res.source),
        .i_cfg  (i_cfg.sink)
    );

    t_cell         span_lo [MAX_RANGES];
    t_cell         span_hi [MAX_RANGES];
    int            span_num;
    t_cell         free_cells;
    t_claim_result pending_results[$];
    int            error_count;
    int            hold_off;
    bit            sender_bursty;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic reload_spans(input t_cell total);
        span_num = (total == '0) ? 0 : 1;
        span_lo[0] = 1;
        span_hi[0] = total;
        free_cells = total;
    endtask

    function automatic t_claim_result claim_range(input t_cell lo, input t_cell hi);
        t_claim_result r;
        int first;
        int last;
        int pieces;
        int shift;
        bit cut_left;
        bit cut_right;
        t_cell left_lo;
        t_cell right_hi;
        t_cell taken;
        t_cell s;
        t_cell e;
        r.free_count = free_cells;
        r.status = ST_DONE;
        if (lo > hi) begin
            r.status = ST_ORDER;
            return r;
        end
        first = 0;
        while (first < span_num && span_hi[first] < lo) first++;
        last = first;
        while (last < span_num && span_lo[last] <= hi) last++;
        if (last == first) return r;
        cut_left = span_lo[first] < lo;
        cut_right = span_hi[last-1] > hi;
        pieces = int'(cut_left) + int'(cut_right);
        if (span_num - (last - first) + pieces > MAX_RANGES) begin
            r.status = ST_FULL;
            return r;
        end
        left_lo = span_lo[first];
        right_hi = span_hi[last-1];
        taken = '0;
        for (int i = first; i < last; i++) begin
            s = (span_lo[i] > lo) ? span_lo[i] : lo;
            e = (span_hi[i] < hi) ? span_hi[i] : hi;
            taken += e - s + 1;
        end
        shift = first + pieces - last;
        if (shift < 0) begin
            for (int i = last; i < span_num; i++) begin
                span_lo[i+shift] = span_lo[i];
                span_hi[i+shift] = span_hi[i];
            end
        end else if (shift > 0) begin
            for (int i = span_num - 1; i >= last; i--) begin
                span_lo[i+shift] = span_lo[i];
                span_hi[i+shift] = span_hi[i];
            end
        end
        if (cut_left) begin
            span_lo[first] = left_lo;
            span_hi[first] = lo - 1;
        end
        if (cut_right) begin
            span_lo[first+int'(cut_left)] = hi + 1;
            span_hi[first+int'(cut_left)] = right_hi;
        end
        span_num += shift;
        free_cells -= taken;
        r.free_count = free_cells;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_cell got, input t_cell want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_claim(input t_cell lo, input t_cell hi);
        if (sender_bursty && $urandom_range(0, 3) == 0) begin
            i_req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_req.valid <= 1'b1;
        i_req.range_low <= lo;
        i_req.range_high <= hi;
        @(posedge i_clk);
        while (!i_req.ready) @(posedge i_clk);
        pending_results = {pending_results, claim_range(lo, hi)};
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_req.valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * MAX_RANGES + 10) @(posedge i_clk);
    endtask

    task automatic write_total(input t_cell total);
        wait_drained();
        i_cfg.valid <= 1'b1;
        i_cfg.data <= total;
        @(posedge i_clk);
        while (!i_cfg.ready) @(posedge i_clk);
        i_cfg.valid <= 1'b0;
        reload_spans(total);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_claim_result want;
        if (i_rst_n && o_res.valid && o_res.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", o_res.free_count, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.free_count !== want.free_count)
                    report_mismatch("free_count", o_res.free_count, want.free_count);
                if (o_res.status !== want.status)
                    report_mismatch("status", t_cell'(o_res.status), t_cell'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            o_res.ready <= 1'b0;
        end else begin
            o_res.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    task automatic test_directed();
        t_cell top;
        top = '1;
        send_claim(0, 0);
        send_claim(5, 4);
        send_claim(top, 0);
        send_claim(1, 1);
        send_claim(1024, 1024);
        send_claim(100, 200);
        send_claim(150, 160);
        send_claim(50, 300);
        send_claim(2000, top);
        send_claim(0, top);
        write_total(top);
        send_claim(top, top);
        send_claim(32'h5555_5555, 32'hAAAA_AAAA);
        send_claim(32'h0000_0002, 32'h0000_0002);
        send_claim(0, top);
        write_total(0);
        send_claim(1, 10);
        send_claim(0, top);
        write_total(1);
        send_claim(1, 1);
    endtask

    task automatic test_table_full();
        write_total(2 * MAX_RANGES + 8);
        for (int i = 1; i <= MAX_RANGES; i++) send_claim(2 * i, 2 * i);
        send_claim(3, 3);
        send_claim(2 * MAX_RANGES + 5, 2 * MAX_RANGES + 5);
        send_claim(1, 2);
        send_claim(2 * MAX_RANGES + 5, 2 * MAX_RANGES + 5);
    endtask

    task automatic test_backpressure();
        write_total(4096);
        hold_off = 1500;
        for (int i = 0; i < 8; i++) send_claim(10 * i + 5, 10 * i + 7);
        wait_drained();
        for (int i = 0; i < 4; i++) send_claim($urandom_range(1, 4096), 4096);
    endtask

    task automatic test_random();
        t_cell total;
        t_cell lo;
        t_cell hi;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: total = 1024;
                1: total = '1;
                2: total = $urandom();
                default: total = $urandom_range(16, 600);
            endcase
            write_total(total);
            sender_bursty = (phase % 2 == 0);
            for (int n = 0; n < 220; n++) begin
                if (phase == 1 || phase == 2 || $urandom_range(0, 15) == 0) begin
                    lo = $urandom();
                    hi = $urandom();
                    if ($urandom_range(0, 4) != 0 && lo > hi) {lo, hi} = {hi, lo};
                end else begin
                    lo = $urandom_range(0, total + 2);
                    hi = lo + $urandom_range(0, 8);
                    if ($urandom_range(0, 9) == 0) hi = lo - 1;
                end
                send_claim(lo, hi);
            end
        end
        sender_bursty = 1'b0;
    endtask

    initial begin
        error_count = 0;
        hold_off = 0;
        sender_bursty = 1'b0;
        i_rst_n <= 1'b0;
        i_req.valid <= 1'b0;
        i_req.range_low <= '0;
        i_req.range_high <= '0;
        i_cfg.valid <= 1'b0;
        i_cfg.data <= '0;
        reload_spans(TOTAL_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        wait_drained();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
